// File: design/etcf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables for the epoch to calendar converter
// no dependencies

package etcf_pkg;

    localparam int EpochW    = 32;
    localparam int OffsetW   = 17;
    localparam int YearW     = 12;
    localparam int RemW      = 16;
    localparam int QuoW      = 16;
    localparam int MulAW     = 25;
    localparam int MulBW     = 26;
    localparam int ProdW     = MulAW + MulBW;
    localparam int CfgIdxW   = 3;
    localparam int OutDataW  = 64;

    // units taken back out of the dividend once the quotient is known
    localparam logic [EpochW-1:0] DaySec   = 32'd86400;
    localparam logic [EpochW-1:0] HourSec  = 32'd3600;
    localparam logic [EpochW-1:0] MinSec   = 32'd60;
    localparam logic [EpochW-1:0] WeekDays = 32'd7;

    // rounded-up reciprocals of the odd divisor parts, power-of-two part shifted out first
    localparam logic [MulBW-1:0] RecipDay  = 26'd50903317;  // 2^35 / 675
    localparam logic [MulBW-1:0] RecipHour = 26'd9321;      // 2^21 / 225
    localparam logic [MulBW-1:0] RecipMin  = 26'd1093;      // 2^14 / 15
    localparam logic [MulBW-1:0] RecipWday = 26'd74899;     // 2^19 / 7

    localparam logic [YearW-1:0] EpochYear   = 12'd1970;
    localparam logic [6:0]       EpochMod100 = 7'd70;
    localparam logic [8:0]       EpochMod400 = 9'd370;
    localparam logic [15:0]      WdayBias    = 16'd4;

    localparam logic [CfgIdxW-1:0] CfgZone   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgAnnMon = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgAnnDay = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgOrigin = 3'd3;

    localparam logic [OffsetW-1:0] RstZone   = 17'd19800;
    localparam logic [3:0]         RstAnnMon = 4'd9;
    localparam logic [4:0]         RstAnnDay = 5'd10;
    localparam logic [YearW-1:0]   RstOrigin = 12'd2004;

    typedef enum logic [1:0] {
        PH_DAY  = 2'd0,
        PH_HOUR = 2'd1,
        PH_MIN  = 2'd2,
        PH_WDAY = 2'd3
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   div_step;
        logic   next;
        logic   yr_step;
        logic   mo_step;
        logic   capture;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_status;

    typedef struct packed {
        logic [OffsetW-1:0] zone_offset_seconds;
        logic [3:0]         anniversary_month;
        logic [4:0]         anniversary_day;
        logic [YearW-1:0]   origin_year;
    } t_cfg;

    // first member is the highest bits
    typedef struct packed {
        logic [7:0]       years_since_origin;
        logic             anniversary_hit;
        logic [YearW-1:0] year_number;
        logic [8:0]       day_of_year;
        logic [3:0]       month_number;
        logic [4:0]       day_of_month;
        logic [2:0]       weekday;
        logic [5:0]       second_value;
        logic [5:0]       minute_value;
        logic             is_afternoon;
        logic [3:0]       hour_twelve;
    } t_result;

    localparam int ResultW = $bits(t_result);

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd1:                                      len = 5'd28;
            default:                                   len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

// File: design/etcf_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the converter: divider phases, year and month search, result handoff
// depends on etcf_pkg

module etcf_ctrl import etcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_NEXT  = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic            r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = PH_DAY;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = S_DIV;
                unique case (r_phase)
                    PH_DAY: begin
                        n_phase = PH_HOUR;
                    end
                    PH_HOUR: begin
                        n_phase = PH_MIN;
                    end
                    PH_MIN: begin
                        n_phase = PH_WDAY;
                    end
                    PH_WDAY: begin
                        n_state = S_YEAR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_YEAR: begin
                o_cmd.yr_step = 1'b1;
                if (i_status.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                o_cmd.mo_step = 1'b1;
                if (i_status.month_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_DAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/etcf_dp.sv
`timescale 1ns / 1ps
// datapath: shared reciprocal multiplier, year and month search, result register
// depends on etcf_pkg

module etcf_dp import etcf_pkg::*; (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    input  logic [EpochW-1:0] i_epoch,
    output t_status           o_status,
    output t_result           o_result
);

    logic [EpochW-1:0] r_num;
    logic [QuoW-1:0]   r_quo;
    logic [15:0]       r_days;
    logic [4:0]        r_h24;
    logic [5:0]        r_minute;
    logic [5:0]        r_second;
    logic [2:0]        r_wday;
    logic [RemW-1:0]   r_rem;
    logic [YearW-1:0]  r_year;
    logic [6:0]        r_c100;
    logic [8:0]        r_c400;
    logic [3:0]        r_month;
    logic [8:0]        r_doy;
    t_result           r_result;

    logic [MulAW-1:0]  w_mul_a;
    logic [MulBW-1:0]  w_mul_b;
    logic [ProdW-1:0]  w_prod;
    logic [QuoW-1:0]   w_quo;
    logic              w_leap;
    logic [8:0]        w_yd;
    logic [4:0]        w_md;
    logic              w_year_done;
    logic              w_month_done;
    logic [EpochW-1:0] w_local;
    t_result           w_result;
    logic [3:0]        w_h12;
    logic [YearW-1:0]  w_diff;
    logic [3:0]        w_month_num;
    logic [4:0]        w_dom;

    assign w_local = i_epoch + {{(EpochW-OffsetW){i_cfg.zone_offset_seconds[OffsetW-1]}},
                                i_cfg.zone_offset_seconds};

    always_comb begin
        unique case (i_cmd.phase)
            PH_DAY: begin
                w_mul_a = r_num[EpochW-1:7];
                w_mul_b = RecipDay;
            end
            PH_HOUR: begin
                w_mul_a = {12'd0, r_num[16:4]};
                w_mul_b = RecipHour;
            end
            PH_MIN: begin
                w_mul_a = {15'd0, r_num[11:2]};
                w_mul_b = RecipMin;
            end
            PH_WDAY: begin
                w_mul_a = {9'd0, r_num[15:0]};
                w_mul_b = RecipWday;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = {{MulBW{1'b0}}, w_mul_a} * {{MulAW{1'b0}}, w_mul_b};

    always_comb begin
        unique case (i_cmd.phase)
            PH_DAY:  w_quo = w_prod[ProdW-1:35];
            PH_HOUR: w_quo = w_prod[36:21];
            PH_MIN:  w_quo = w_prod[29:14];
            PH_WDAY: w_quo = w_prod[34:19];
            default: w_quo = '0;
        endcase
    end

    assign w_leap = ((r_year[1:0] == 2'd0) && (r_c100 != 7'd0)) || (r_c400 == 9'd0);
    assign w_yd   = w_leap ? 9'd366 : 9'd365;
    assign w_md   = ((r_month == 4'd1) && w_leap) ? 5'd29 : month_len(r_month);

    assign w_year_done  = (r_rem < {{(RemW-9){1'b0}}, w_yd});
    assign w_month_done = (r_month == 4'd11) || (r_rem < {{(RemW-5){1'b0}}, w_md});

    assign o_status.year_done  = w_year_done;
    assign o_status.month_done = w_month_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= w_local;
        end else if (i_cmd.div_step) begin
            r_quo <= w_quo;
        end else if (i_cmd.next) begin
            unique case (i_cmd.phase)
                PH_DAY: begin
                    r_days <= r_quo;
                    r_num  <= r_num - {{(EpochW-QuoW){1'b0}}, r_quo} * DaySec;
                end
                PH_HOUR: begin
                    r_h24 <= r_quo[4:0];
                    r_num <= r_num - {{(EpochW-QuoW){1'b0}}, r_quo} * HourSec;
                end
                PH_MIN: begin
                    r_minute <= r_quo[5:0];
                    r_second <= 6'(r_num - {{(EpochW-QuoW){1'b0}}, r_quo} * MinSec);
                    r_num    <= {16'd0, r_days + WdayBias};
                end
                PH_WDAY: begin
                    r_wday  <= 3'(r_num - {{(EpochW-QuoW){1'b0}}, r_quo} * WeekDays);
                    r_rem   <= r_days;
                    r_year  <= EpochYear;
                    r_c100  <= EpochMod100;
                    r_c400  <= EpochMod400;
                    r_month <= '0;
                end
                default: begin
                    r_quo <= '0;
                end
            endcase
        end else if (i_cmd.yr_step) begin
            if (w_year_done) begin
                r_doy <= r_rem[8:0] + 9'd1;
            end else begin
                r_rem  <= r_rem - {{(RemW-9){1'b0}}, w_yd};
                r_year <= r_year + 1'b1;
                r_c100 <= (r_c100 == 7'd99) ? 7'd0 : r_c100 + 7'd1;
                r_c400 <= (r_c400 == 9'd399) ? 9'd0 : r_c400 + 9'd1;
            end
        end else if (i_cmd.mo_step) begin
            if (!w_month_done) begin
                r_rem   <= r_rem - {{(RemW-5){1'b0}}, w_md};
                r_month <= r_month + 4'd1;
            end
        end
        if (i_cmd.capture) begin
            r_result <= w_result;
        end
    end

    always_comb begin
        w_h12       = (r_h24 >= 5'd12) ? 4'(r_h24 - 5'd12) : r_h24[3:0];
        w_diff      = r_year - i_cfg.origin_year;
        w_month_num = r_month + 4'd1;
        w_dom       = r_rem[4:0] + 5'd1;

        w_result.hour_twelve     = (w_h12 == 4'd0) ? 4'd12 : w_h12;
        w_result.is_afternoon    = (r_h24 >= 5'd12);
        w_result.minute_value    = r_minute;
        w_result.second_value    = r_second;
        w_result.weekday         = r_wday;
        w_result.day_of_month    = w_dom;
        w_result.month_number    = w_month_num;
        w_result.day_of_year     = r_doy;
        w_result.year_number     = r_year;
        w_result.anniversary_hit = (w_month_num == i_cfg.anniversary_month) &&
                                   (w_dom == i_cfg.anniversary_day);
        if (r_year < i_cfg.origin_year) begin
            w_result.years_since_origin = 8'd0;
        end else if (w_diff > 12'd255) begin
            w_result.years_since_origin = 8'd255;
        end else begin
            w_result.years_since_origin = w_diff[7:0];
        end
    end

    assign o_result = r_result;

endmodule

// File: design/epoch_to_calendar_fields_core.sv
`timescale 1ns / 1ps
// top level of the epoch to calendar converter: config registers and stream ports
// depends on etcf_pkg, etcf_ctrl, etcf_dp

// Converts a 32-bit UTC second count, shifted by the zone offset register, into
// 12-hour time, weekday, Gregorian date, an anniversary match flag and years since
// the origin year. One item is in work at a time: the divider phases run first,
// then the year search from 1970 and the month search up to the result month.
// The year search in the datapath, one year per cycle, is the longest step. A
// finished result waits in the output register while the next item is
// taken. Configuration writes are always accepted and should be made while idle.

module epoch_to_calendar_fields_core import etcf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [EpochW-1:0]   s_axis_tdata,   // [31:0] epoch_seconds
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [3:0] hour_twelve, [4] is_afternoon, [10:5] minute_value, [16:11] second_value,
    // [19:17] weekday, [24:20] day_of_month, [28:25] month_number,
    // [37:29] day_of_year, [49:38] year_number, [50] anniversary_hit,
    // [58:51] years_since_origin, [63:59] zero
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [OffsetW-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_offset_seconds <= RstZone;
            r_cfg.anniversary_month   <= RstAnnMon;
            r_cfg.anniversary_day     <= RstAnnDay;
            r_cfg.origin_year         <= RstOrigin;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgZone:   r_cfg.zone_offset_seconds <= i_cfg_data;
                CfgAnnMon: r_cfg.anniversary_month   <= i_cfg_data[3:0];
                CfgAnnDay: r_cfg.anniversary_day     <= i_cfg_data[4:0];
                CfgOrigin: r_cfg.origin_year         <= i_cfg_data[YearW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    etcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    etcf_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_cfg    (r_cfg),
        .i_epoch  (s_axis_tdata),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign m_axis_tdata = {{(OutDataW-ResultW){1'b0}}, w_result};

endmodule
